// ===== sv/avoidance_mode_supervisor_assert.svh =====
`ifndef AVOIDANCE_MODE_SUPERVISOR_ASSERT_SVH
`define AVOIDANCE_MODE_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define AMS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avoidance mode supervisor: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define AMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avoidance mode supervisor: next-cycle check failed");

`endif

// ===== sv/ams_pkg.sv =====
package ams_pkg;

    localparam int unsigned InWidth   = 7;
    localparam int unsigned InBytes   = (InWidth + 7) / 8;
    localparam int unsigned OutWidth  = 9;
    localparam int unsigned OutBytes  = (OutWidth + 7) / 8;
    localparam int unsigned ModeWidth = 3;
    localparam int unsigned RsnWidth  = 5;

    // Mode state, one-hot internally.
    typedef enum logic [6:0] {
        MODE_NAV     = 7'b0000001,
        MODE_BLOCKED = 7'b0000010,
        MODE_BRAKE   = 7'b0000100,
        MODE_REPLAN  = 7'b0001000,
        MODE_VERIFY  = 7'b0010000,
        MODE_RESUME  = 7'b0100000,
        MODE_HOVER   = 7'b1000000
    } mode_t;

    // Mode codes as seen on the output word.
    localparam logic [ModeWidth-1:0] CODE_NAV     = 3'd0;
    localparam logic [ModeWidth-1:0] CODE_BLOCKED = 3'd1;
    localparam logic [ModeWidth-1:0] CODE_BRAKE   = 3'd2;
    localparam logic [ModeWidth-1:0] CODE_REPLAN  = 3'd3;
    localparam logic [ModeWidth-1:0] CODE_VERIFY  = 3'd4;
    localparam logic [ModeWidth-1:0] CODE_RESUME  = 3'd5;
    localparam logic [ModeWidth-1:0] CODE_HOVER   = 3'd6;

    typedef enum logic [RsnWidth-1:0] {
        RSN_DIRECT          = 5'd0,
        RSN_RAW_STALE       = 5'd1,
        RSN_LOC_DEGRADED    = 5'd2,
        RSN_MISSION_STALE   = 5'd3,
        RSN_BLOCKED         = 5'd4,
        RSN_BRAKE           = 5'd5,
        RSN_HELD            = 5'd6,
        RSN_CANDIDATE       = 5'd7,
        RSN_PLAN_FAILED     = 5'd8,
        RSN_TRAJ_VERIFIED   = 5'd9,
        RSN_TRAJ_FAILED     = 5'd10,
        RSN_REBLOCKED       = 5'd11,
        RSN_DETOUR_DONE     = 5'd12,
        RSN_DETOUR_ACTIVE   = 5'd13,
        RSN_LATCHED_BLOCKED = 5'd14,
        RSN_RECOVER_REPLAN  = 5'd15,
        RSN_RECOVER_DIRECT  = 5'd16
    } reason_t;

    typedef struct packed {
        logic map_fresh;
        logic pose_ok;
        logic task_fresh;
        logic route_blocked;
        logic replan_done;
        logic cand_ok;
        logic detour_done;
    } ams_event_t;

    typedef struct packed {
        mode_t   mode;
        reason_t reason;
        logic    failure_latched;
    } ams_state_t;

    function automatic logic [ModeWidth-1:0] mode_code(input mode_t m);
        logic [ModeWidth-1:0] c;
        case (m)
            MODE_NAV:     c = CODE_NAV;
            MODE_BLOCKED: c = CODE_BLOCKED;
            MODE_BRAKE:   c = CODE_BRAKE;
            MODE_REPLAN:  c = CODE_REPLAN;
            MODE_VERIFY:  c = CODE_VERIFY;
            MODE_RESUME:  c = CODE_RESUME;
            default:      c = CODE_HOVER;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/avoidance_mode_supervisor.sv =====
// Avoidance mode supervisor. Each input word is one health and progress event of seven
// flags; each event yields exactly one output word holding the new mode, the reason
// code and the planner-failure latch. A word taken on s_tdata lands in an input
// register; when the output slot is free the mode step is applied to it and the
// result is held in the mode, reason and latch registers, which drive m_tdata
// directly. One word per cycle is sustained when m_tready stays high: the feedback
// through the state registers sets that rate. The input register keeps taking a
// word while a result waits on the output, so a stall on the master side costs
// one word of slack before s_tready drops. After reset the mode is navigating, the
// reason direct and the latch clear.
module avoidance_mode_supervisor
    import ams_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // bit 0 map_fresh, 1 pose_ok, 2 task_fresh, 3 route_blocked,
    // 4 replan_done, 5 cand_ok, 6 detour_done, 7 zero
    input  logic [InBytes*8-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bits 2:0 mode, 7:3 reason_code, 8 failure_latched, 15:9 zero
    output logic [OutBytes*8-1:0] m_tdata
);

`include "avoidance_mode_supervisor_assert.svh"

    ams_event_t ev_reg;
    logic       ev_valid_reg;
    ams_event_t ev_in;
    ams_state_t state_reg;
    ams_state_t state_next;
    logic       out_valid_reg;
    logic       advance;

    // move the held event into the state when the output slot is free
    assign advance  = ev_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !ev_valid_reg || advance;

    assign ev_in.map_fresh     = s_tdata[0];
    assign ev_in.pose_ok       = s_tdata[1];
    assign ev_in.task_fresh    = s_tdata[2];
    assign ev_in.route_blocked = s_tdata[3];
    assign ev_in.replan_done   = s_tdata[4];
    assign ev_in.cand_ok       = s_tdata[5];
    assign ev_in.detour_done   = s_tdata[6];

    // input register: payload without reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ev_reg <= ev_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            ev_valid_reg <= s_tvalid;
        end
    end

    ams_step u_step
    (
        .ev  (ev_reg),
        .cur (state_reg),
        .nxt (state_next)
    );

    // state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode            <= MODE_NAV;
            state_reg.reason          <= RSN_DIRECT;
            state_reg.failure_latched <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutBytes*8-OutWidth){1'b0}}, state_reg.failure_latched,
                       state_reg.reason, mode_code(state_reg.mode)};

    // mode register stays one-hot
    `AMS_ASSERT_IMPL(a_mode_onehot, 1'b1, $onehot(state_reg.mode))
    // state moves only when an event is consumed
    `AMS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_reg))
    // an unhealthy event always forces hover
    `AMS_ASSERT_NEXT(a_unhealthy_hover,
        advance && (!ev_reg.map_fresh || !ev_reg.pose_ok || !ev_reg.task_fresh),
        state_reg.mode == MODE_HOVER)
    // latch sets only from a failed replan or verify
    `AMS_ASSERT_IMPL(a_latch_source, $rose(state_reg.failure_latched),
        $past(state_reg.mode) == MODE_REPLAN || $past(state_reg.mode) == MODE_VERIFY)

endmodule

// ===== sv/ams_step.sv =====
module ams_step
    import ams_pkg::*;
(
    input  ams_event_t ev,
    input  ams_state_t cur,
    output ams_state_t nxt
);

    always_comb
    begin
        nxt = cur;
        if (!ev.map_fresh)
        begin
            nxt.mode   = MODE_HOVER;
            nxt.reason = RSN_RAW_STALE;
        end
        else if (!ev.pose_ok)
        begin
            nxt.mode   = MODE_HOVER;
            nxt.reason = RSN_LOC_DEGRADED;
        end
        else if (!ev.task_fresh)
        begin
            nxt.mode   = MODE_HOVER;
            nxt.reason = RSN_MISSION_STALE;
        end
        else
        begin
            case (cur.mode)
                MODE_NAV:
                begin
                    if (ev.route_blocked)
                    begin
                        nxt.mode   = MODE_BLOCKED;
                        nxt.reason = RSN_BLOCKED;
                    end
                    else
                    begin
                        nxt.reason = RSN_DIRECT;
                    end
                end
                MODE_BLOCKED:
                begin
                    nxt.mode   = MODE_BRAKE;
                    nxt.reason = RSN_BRAKE;
                end
                MODE_BRAKE:
                begin
                    nxt.mode   = MODE_REPLAN;
                    nxt.reason = RSN_HELD;
                end
                MODE_REPLAN:
                begin
                    // hold mode and reason until an attempt finishes
                    if (ev.replan_done)
                    begin
                        nxt.mode            = ev.cand_ok ? MODE_VERIFY : MODE_HOVER;
                        nxt.failure_latched = !ev.cand_ok;
                        nxt.reason          = ev.cand_ok ? RSN_CANDIDATE
                                                         : RSN_PLAN_FAILED;
                    end
                end
                MODE_VERIFY:
                begin
                    nxt.mode            = ev.cand_ok ? MODE_RESUME : MODE_HOVER;
                    nxt.failure_latched = !ev.cand_ok;
                    nxt.reason          = ev.cand_ok ? RSN_TRAJ_VERIFIED
                                                     : RSN_TRAJ_FAILED;
                end
                MODE_RESUME:
                begin
                    if (ev.route_blocked)
                    begin
                        nxt.mode   = MODE_BLOCKED;
                        nxt.reason = RSN_REBLOCKED;
                    end
                    else if (ev.detour_done)
                    begin
                        nxt.mode   = MODE_NAV;
                        nxt.reason = RSN_DETOUR_DONE;
                    end
                    else
                    begin
                        nxt.reason = RSN_DETOUR_ACTIVE;
                    end
                end
                default:
                begin
                    if (cur.failure_latched && ev.route_blocked)
                    begin
                        nxt.mode   = MODE_HOVER;
                        nxt.reason = RSN_LATCHED_BLOCKED;
                    end
                    else if (ev.route_blocked)
                    begin
                        nxt.mode   = MODE_BRAKE;
                        nxt.reason = RSN_RECOVER_REPLAN;
                    end
                    else
                    begin
                        nxt.mode            = MODE_NAV;
                        nxt.failure_latched = 1'b0;
                        nxt.reason          = RSN_RECOVER_DIRECT;
                    end
                end
            endcase
        end
    end

endmodule

// ===== bench/tb_avoidance_mode_supervisor.sv =====
`timescale 1ns / 100ps

module tb_avoidance_mode_supervisor
    import ams_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_PER_PHASE = 440;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // bit 0 map_fresh, 1 pose_ok, 2 task_fresh, 3 route_blocked,
    // 4 replan_done, 5 cand_ok, 6 detour_done, 7 zero
    logic [InBytes*8-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // bits 2:0 mode, 7:3 reason_code, 8 failure_latched, 15:9 zero
    logic [OutBytes*8-1:0] m_tdata;

    avoidance_mode_supervisor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicted supervisor state, advanced once per accepted input word.
    logic [ModeWidth-1:0]  pred_mode;
    reason_t               pred_reason;
    logic                  pred_latch;

    // Result words still owed by the block, oldest first.
    logic [OutBytes*8-1:0] owed_results[$];

    int unsigned           events_sent;
    int unsigned           results_checked = 0;
    int unsigned           mismatches = 0;
    int unsigned           cycle_count = 0;
    logic [16:0]           reasons_reached;
    logic [7:0]            modes_reached;

    // Knobs set by the test tasks and read by the two bus processes.
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           hold_epoch = 0;
    int unsigned           hold_seen = 0;
    int unsigned           hold_left = 0;

    // Free-running clock, period 20 ns.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Guard the whole run against a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results still owed",
                     cycle_count, owed_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Advance the predicted state by one event and return the word it should yield.
    // The health flags win in their fixed order; only a fully healthy event moves
    // the mode machine.
    function automatic logic [OutBytes*8-1:0] step_supervisor(input logic [6:0] ev);
        logic raw;
        logic loc;
        logic mis;
        logic blk;
        logic att;
        logic val;
        logic gol;
        raw = ev[0];
        loc = ev[1];
        mis = ev[2];
        blk = ev[3];
        att = ev[4];
        val = ev[5];
        gol = ev[6];
        if (!raw)
        begin
            pred_mode   = CODE_HOVER;
            pred_reason = RSN_RAW_STALE;
        end
        else if (!loc)
        begin
            pred_mode   = CODE_HOVER;
            pred_reason = RSN_LOC_DEGRADED;
        end
        else if (!mis)
        begin
            pred_mode   = CODE_HOVER;
            pred_reason = RSN_MISSION_STALE;
        end
        else
        begin
            case (pred_mode)
                CODE_NAV:
                begin
                    if (blk)
                    begin
                        pred_mode   = CODE_BLOCKED;
                        pred_reason = RSN_BLOCKED;
                    end
                    else
                        pred_reason = RSN_DIRECT;
                end
                CODE_BLOCKED:
                begin
                    pred_mode   = CODE_BRAKE;
                    pred_reason = RSN_BRAKE;
                end
                CODE_BRAKE:
                begin
                    pred_mode   = CODE_REPLAN;
                    pred_reason = RSN_HELD;
                end
                CODE_REPLAN:
                begin
                    // No finished attempt: hold mode and reason as they are.
                    if (att)
                    begin
                        pred_mode   = val ? CODE_VERIFY : CODE_HOVER;
                        pred_latch  = !val;
                        pred_reason = val ? RSN_CANDIDATE : RSN_PLAN_FAILED;
                    end
                end
                CODE_VERIFY:
                begin
                    pred_mode   = val ? CODE_RESUME : CODE_HOVER;
                    pred_latch  = !val;
                    pred_reason = val ? RSN_TRAJ_VERIFIED : RSN_TRAJ_FAILED;
                end
                CODE_RESUME:
                begin
                    if (blk)
                    begin
                        pred_mode   = CODE_BLOCKED;
                        pred_reason = RSN_REBLOCKED;
                    end
                    else if (gol)
                    begin
                        pred_mode   = CODE_NAV;
                        pred_reason = RSN_DETOUR_DONE;
                    end
                    else
                        pred_reason = RSN_DETOUR_ACTIVE;
                end
                default:
                begin
                    // Hover required; the spare encoding falls in here as well.
                    if (pred_latch && blk)
                    begin
                        pred_mode   = CODE_HOVER;
                        pred_reason = RSN_LATCHED_BLOCKED;
                    end
                    else if (blk)
                    begin
                        pred_mode   = CODE_BRAKE;
                        pred_reason = RSN_RECOVER_REPLAN;
                    end
                    else
                    begin
                        pred_mode   = CODE_NAV;
                        pred_latch  = 1'b0;
                        pred_reason = RSN_RECOVER_DIRECT;
                    end
                end
            endcase
        end
        reasons_reached[pred_reason] = 1'b1;
        modes_reached[pred_mode]     = 1'b1;
        return {{(OutBytes*8-9){1'b0}}, pred_latch, pred_reason, pred_mode};
    endfunction

    // Fully healthy event carrying the given progress flags.
    function automatic logic [6:0] healthy_event(input logic blk, input logic att,
                                                 input logic val, input logic gol);
        return {gol, val, att, blk, 3'b111};
    endfunction

    // Offer one event word and hold it until the block takes it. Called and left at
    // a falling edge; valid is only lowered inside an idle gap, never just before a
    // word goes out in the same step.
    task automatic send_event(input logic [6:0] ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InBytes*8-7){1'b0}}, ev};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        owed_results.insert(owed_results.size(), step_supervisor(ev));
        events_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every owed word has come back, then let the pipe settle.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Mostly healthy events with random progress flags, so the mode machine walks its
    // whole cycle; now and then a fault event with at least one health flag low.
    function automatic logic [6:0] random_event();
        logic [6:0] ev;
        logic [2:0] pick;
        if ($urandom_range(99) < 88)
            ev = healthy_event($urandom_range(99) < 45, $urandom_range(99) < 55,
                               $urandom_range(99) < 70, $urandom_range(99) < 40);
        else
        begin
            ev   = 7'($urandom_range(127));
            pick = 3'($urandom_range(2));
            if (ev[2:0] == 3'b111)
                ev[pick] = 1'b0;
        end
        return ev;
    endfunction

    // Walk every mode and every reason code except the failed verification in a fixed
    // order, including the replan that waits without an attempt, the health faults with
    // the latch set, and the all-zero and all-one words.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));    // navigating, direct
        send_event(healthy_event(1'b1, 1'b0, 1'b0, 1'b0));    // path blocked
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));    // brake
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));    // held for replan
        send_event(healthy_event(1'b1, 1'b0, 1'b1, 1'b1));    // replan, no attempt: hold
        send_event(healthy_event(1'b0, 1'b1, 1'b1, 1'b0));    // candidate generated
        send_event(healthy_event(1'b0, 1'b0, 1'b1, 1'b0));    // trajectory verified
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));    // detour still active
        send_event(healthy_event(1'b1, 1'b0, 1'b0, 1'b0));    // reblocked
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));
        send_event(healthy_event(1'b1, 1'b1, 1'b0, 1'b0));    // planner failed, latch set
        send_event(healthy_event(1'b1, 1'b0, 1'b0, 1'b0));    // latched and still blocked
        send_event(7'b1111110);                               // raw map stale, latch kept
        send_event(7'b1111101);                               // localization degraded
        send_event(7'b1111011);                               // mission stale
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));    // recovered direct
        send_event(healthy_event(1'b1, 1'b0, 1'b0, 1'b0));
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));
        send_event(healthy_event(1'b0, 1'b1, 1'b1, 1'b0));
        send_event(healthy_event(1'b1, 1'b0, 1'b0, 1'b0));    // replan, no attempt: hold
        send_event(7'b0000000);                               // everything stale
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b0));    // recovered, latch clear
        send_event(7'b1111110);                               // hover with latch clear
        send_event(healthy_event(1'b1, 1'b0, 1'b0, 1'b0));    // recovered to replan
        send_event(7'b1111111);                               // all ones from brake
        send_event(healthy_event(1'b0, 1'b1, 1'b1, 1'b0));
        send_event(healthy_event(1'b0, 1'b0, 1'b1, 1'b0));
        send_event(healthy_event(1'b0, 1'b0, 1'b0, 1'b1));    // local detour complete
        wait_all_results();
    endtask

    // One block of random events under the given idling on each side.
    task automatic test_random_phase(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE)
            send_event(random_event());
        wait_all_results();
    endtask

    // Hold the output off for a long stretch while events keep coming, so the block
    // fills up and drops s_tready; then release and drain.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_epoch++;
        repeat (40)
            send_event(random_event());
        wait_all_results();
    endtask

    // Output side: random stalls, plus a long hold-off counted here when asked for.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_epoch != hold_seen)
            begin
                hold_seen = hold_epoch;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each word taken from the block with the oldest owed word.
    always @(posedge clk)
    begin
        logic [OutBytes*8-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h with no result owed", m_tdata);
            end
            else
            begin
                want = owed_results.pop_front();
                results_checked++;
                if (m_tdata[2:0] !== want[2:0] || m_tdata[7:3] !== want[7:3]
                    || m_tdata[8] !== want[8] || m_tdata[OutBytes*8-1:9] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected mode %0d reason %0d latch %0d",
                                 results_checked, want[2:0], want[7:3], want[8]);
                        $display("    got mode %0d reason %0d latch %0d (word %h)",
                                 m_tdata[2:0], m_tdata[7:3], m_tdata[8], m_tdata);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        events_sent     = 0;
        reasons_reached = '0;
        modes_reached   = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        pred_mode       = CODE_NAV;
        pred_reason     = RSN_DIRECT;
        pred_latch      = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_phase(0, 0);
        test_backpressure();
        test_random_phase(47, 0);
        test_random_phase(0, 47);
        test_random_phase(29, 29);

        // Last drain: wait until nothing is owed, then settle for stray words.
        wait_all_results();

        $display("tb: %0d events sent under idle, stall and hold-off phases",
                 events_sent);
        $display("tb: %0d words checked, %0d mismatches, %0d of 17 reasons, %0d of 7 modes",
                 results_checked, mismatches, $countones(reasons_reached),
                 $countones(modes_reached));
        if (mismatches == 0 && owed_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ams_pkg.sv
sv/ams_step.sv
sv/avoidance_mode_supervisor.sv
bench/tb_avoidance_mode_supervisor.sv
